// ===== rtl/core/trimmed_mean_adc_channel_voltage_top_defines.svh =====
// Assertion macros used by the core RTL controller (tmacv_ctrl).
`ifndef TRIMMED_MEAN_ADC_CHANNEL_VOLTAGE_TOP_DEFINES_SVH
`define TRIMMED_MEAN_ADC_CHANNEL_VOLTAGE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TMACV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TMACV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TMACV_ASSERT(lbl, prop, msg)
`define TMACV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/tmacv_pkg.sv =====
`default_nettype none
package tmacv_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned CH_FIELD_W = 4;
  localparam int unsigned MV_W       = 13;
  localparam int unsigned CHANS_W    = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 16;

  localparam int unsigned WINDOW_DEF   = 16;
  localparam int unsigned CHANNELS_DEF = 16;

  localparam logic [MV_W-1:0]     FULL_SCALE_RST = 13'd3000;
  localparam logic [CHANS_W-1:0]  CHANS_RST      = 5'd13;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = 12'hFFF;

  localparam int unsigned FULL_CODE   = 4095;
  localparam int unsigned PROD_W      = SAMPLE_W + MV_W;
  localparam int unsigned SCALE_SHIFT = PROD_W;
  localparam int unsigned SCALE_RECIP = (2 ** SCALE_SHIFT) / FULL_CODE;
  localparam int unsigned RECIP_W     = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 2'd1;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_TRIM,
    ST_DIV,
    ST_FIX,
    ST_SCALE,
    ST_RECIP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic mem_clear;
    logic store_en;
    logic read_start;
    logic read_en;
    logic trim_en;
    logic div_en;
    logic fix_en;
    logic scale_en;
    logic recip_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rd_last;
    logic in_read;
    logic in_reject;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/trimmed_mean_adc_channel_voltage_top.sv =====
// Store transaction: accepted while idle, no result.
// Read transaction: the window is walked one sample memory entry per cycle through a single
// compare-add unit, then passes states DRAIN, TRIM, DIV, FIX, SCALE and RECIP to DONE, where
// the result loads; next transaction the cycle after the load; a held result stalls it.
// Rejected read: skips the walk and goes straight to DONE. Reset: async active low; clears the
// sample memory (WINDOW * 2**ceil(log2 CHANNELS) entries), tready low.
`default_nettype none
module trimmed_mean_adc_channel_voltage_top
  import tmacv_pkg::*;
#(
  parameter int unsigned WINDOW   = WINDOW_DEF,
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,   // channel[3:0], sample[15:4]
  input  wire logic                  s_axis_tuser,   // operation
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata,   // millivolts[12:0], zero[15:13]
  output logic                       m_axis_tuser    // channel_invalid
);

  cmd_t            cmd;
  status_t         status;
  logic [MV_W-1:0] out_mv;

  tmacv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tmacv_dp #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (s_axis_tuser),
    .in_ch_i     (s_axis_tdata[CH_FIELD_W-1:0]),
    .in_sample_i (s_axis_tdata[CH_FIELD_W +: SAMPLE_W]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_mv_o    (out_mv),
    .out_inv_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {{(M_TDATA_W - MV_W){1'b0}}, out_mv};

endmodule
`default_nettype wire

// ===== rtl/core/tmacv_ctrl.sv =====
`default_nettype none
`include "trimmed_mean_adc_channel_voltage_top_defines.svh"
module tmacv_ctrl
  import tmacv_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && status_i.in_read) begin
          state_d = status_i.in_reject ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        if (status_i.rd_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_TRIM;
      ST_TRIM:  state_d = ST_DIV;
      ST_DIV:   state_d = ST_FIX;
      ST_FIX:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_RECIP;
      ST_RECIP: state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.mem_clear = 1'b1;
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.store_en   = in_valid_i && !status_i.in_read;
        cmd_o.read_start = in_valid_i && status_i.in_read;
      end
      ST_READ:  cmd_o.read_en  = 1'b1;
      ST_DRAIN: ;
      ST_TRIM:  cmd_o.trim_en  = 1'b1;
      ST_DIV:   cmd_o.div_en   = 1'b1;
      ST_FIX:   cmd_o.fix_en   = 1'b1;
      ST_SCALE: cmd_o.scale_en = 1'b1;
      ST_RECIP: cmd_o.recip_en = 1'b1;
      ST_DONE:  cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

  `TMACV_ASSERT(a_load_free, cmd_o.out_load |-> status_i.out_free, "result overwritten")
  `TMACV_ASSERT(a_read_drain, (state_q == ST_READ) && status_i.rd_last |=> state_q == ST_DRAIN,
                "window walk did not end")
  `TMACV_ASSERT(a_clear_done,
                ($past(state_q) == ST_CLEAR) && (state_q != ST_CLEAR) |-> $past(status_i.clr_last),
                "clearing pass left early")
  `TMACV_ASSERT(a_no_cmd_overlap, $onehot0(cmd_o), "several commands at once")

endmodule
`default_nettype wire

// ===== rtl/core/tmacv_dp.sv =====
`default_nettype none
module tmacv_dp
  import tmacv_pkg::*;
#(
  parameter int unsigned WINDOW   = WINDOW_DEF,
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_op_i,
  input  wire logic [CH_FIELD_W-1:0] in_ch_i,
  input  wire logic [SAMPLE_W-1:0]   in_sample_i,
  input  wire cmd_t                  cmd_i,
  output status_t                    status_o,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [MV_W-1:0]            out_mv_o,
  output logic                       out_inv_o
);

  localparam int unsigned WIN_W   = $clog2(WINDOW);
  localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned AW      = WIN_W + CH_W;
  localparam int unsigned DEPTH   = WINDOW * (2 ** CH_W);
  localparam int unsigned SUM_W   = $clog2(WINDOW * FULL_CODE + 1);
  localparam int unsigned DIV_D   = WINDOW - 2;
  localparam int unsigned DIV_M   = (2 ** SUM_W) / DIV_D;
  localparam int unsigned DIVM_W  = SUM_W + 1;
  localparam int unsigned DPROD_W = SUM_W + DIVM_W;
  localparam int unsigned RPROD_W = PROD_W + RECIP_W;

  logic [MV_W-1:0]    fs_q;
  logic [CHANS_W-1:0] chans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q    <= FULL_SCALE_RST;
      chans_q <= CHANS_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_FULL_SCALE) fs_q <= cfg_data_i[MV_W-1:0];
      if (cfg_idx_i == CFG_CHANNELS)   chans_q <= cfg_data_i[CHANS_W-1:0];
    end
  end

  logic [CH_W-1:0] ch_lo;
  logic            ch_in_range;
  logic            ch_reject;

  assign ch_lo       = in_ch_i[CH_W-1:0];
  assign ch_in_range = {1'b0, in_ch_i} < CHANS_W'(CHANNELS);
  assign ch_reject   = !ch_in_range || ({1'b0, in_ch_i} >= chans_q);

  logic [WIN_W-1:0] wpos_q [CHANNELS];
  logic [WIN_W-1:0] wpos_cur;
  logic [WIN_W-1:0] wpos_nxt;

  assign wpos_cur = wpos_q[ch_lo];
  assign wpos_nxt = (wpos_cur == WIN_W'(WINDOW - 1)) ? '0 : wpos_cur + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) wpos_q[i] <= '0;
    end else if (cmd_i.store_en && ch_in_range) begin
      wpos_q[ch_lo] <= wpos_nxt;
    end
  end

  logic [AW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.read_start) begin
      cnt_q <= '0;
    end else if (cmd_i.mem_clear || cmd_i.read_en) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  logic [CH_W-1:0] ch_q;
  logic            inv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_start) begin
      ch_q  <= ch_lo;
      inv_q <= ch_reject;
    end
  end

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic                mem_we;
  logic [AW-1:0]       waddr;
  logic [SAMPLE_W-1:0] wdata;
  logic [AW-1:0]       raddr;

  assign mem_we = cmd_i.mem_clear || (cmd_i.store_en && ch_in_range);
  assign waddr  = cmd_i.mem_clear ? cnt_q : {wpos_cur, ch_lo};
  assign wdata  = cmd_i.mem_clear ? '0 : in_sample_i;
  assign raddr  = {cnt_q[WIN_W-1:0], ch_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wdata;
    if (cmd_i.read_en) rdata_q <= mem_q[raddr];
  end

  logic acc_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= cmd_i.read_en;
    end
  end

  logic [SUM_W-1:0]    total_q;
  logic [SAMPLE_W-1:0] hi_q;
  logic [SAMPLE_W-1:0] lo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_start) begin
      total_q <= '0;
      hi_q    <= '0;
      lo_q    <= SAMPLE_MAX;
    end else if (acc_en_q) begin
      total_q <= total_q + SUM_W'(rdata_q);
      if (rdata_q > hi_q) hi_q <= rdata_q;
      if (rdata_q < lo_q) lo_q <= rdata_q;
    end
  end

  logic [SUM_W-1:0]    x_q;
  logic [DPROD_W-1:0]  dprod_q;
  logic [SAMPLE_W-1:0] dq0;
  logic [SUM_W-1:0]    drem;
  logic [SAMPLE_W-1:0] mean_q;
  logic [PROD_W-1:0]   sprod_q;
  logic [RPROD_W-1:0]  rprod_q;

  assign dq0  = dprod_q[SUM_W +: SAMPLE_W];
  assign drem = x_q - SUM_W'(SUM_W'(dq0) * SUM_W'(DIV_D));

  always_ff @(posedge clk_i) begin
    if (cmd_i.trim_en) x_q <= total_q - SUM_W'(hi_q) - SUM_W'(lo_q);
    if (cmd_i.div_en) dprod_q <= DPROD_W'(x_q) * DPROD_W'(DIV_M);
    if (cmd_i.fix_en) mean_q <= (drem >= SUM_W'(DIV_D)) ? dq0 + 1'b1 : dq0;
    if (cmd_i.scale_en) sprod_q <= PROD_W'(mean_q) * PROD_W'(fs_q);
    if (cmd_i.recip_en) rprod_q <= RPROD_W'(sprod_q) * RPROD_W'(SCALE_RECIP);
  end

  logic [MV_W-1:0]   sq0;
  logic [PROD_W-1:0] srem;
  logic [MV_W-1:0]   mv_res;

  assign sq0    = rprod_q[SCALE_SHIFT +: MV_W];
  assign srem   = sprod_q - ({sq0, {SAMPLE_W{1'b0}}} - PROD_W'(sq0));
  assign mv_res = (srem >= PROD_W'(FULL_CODE)) ? sq0 + 1'b1 : sq0;

  logic            out_valid_q;
  logic [MV_W-1:0] out_mv_q;
  logic            out_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_mv_q  <= inv_q ? '0 : mv_res;
      out_inv_q <= inv_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_mv_o    = out_mv_q;
  assign out_inv_o   = out_inv_q;

  assign status_o.clr_last  = cnt_q == AW'(DEPTH - 1);
  assign status_o.rd_last   = cnt_q[WIN_W-1:0] == WIN_W'(WINDOW - 1);
  assign status_o.in_read   = in_op_i == OP_READ;
  assign status_o.in_reject = ch_reject;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

// ===== bench/voltage_read_checker.sv =====
`default_nettype none
module voltage_read_checker
  import tmacv_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,   // channel[3:0], sample[15:4]
  input  wire logic                  s_axis_tuser,   // operation
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [M_TDATA_W-1:0]  m_axis_tdata,   // millivolts[12:0], zero[15:13]
  input  wire logic                  m_axis_tuser,   // channel_invalid
  output int                         err_count_o,
  output int                         pending_o
);

  localparam int unsigned POS_W = $clog2(WINDOW_DEF);

  typedef struct packed {
    logic [MV_W-1:0] millivolts;
    logic            invalid;
  } reading_t;

  logic [SAMPLE_W-1:0]   ring [CHANNELS_DEF][WINDOW_DEF];
  logic [POS_W-1:0]      wr_pos [CHANNELS_DEF];
  logic [MV_W-1:0]       full_scale;
  logic [CHANS_W-1:0]    chans_in_use;
  reading_t              expected_readings [$];
  reading_t              want;
  logic                  in_op;
  logic [CH_FIELD_W-1:0] in_ch;
  logic [SAMPLE_W-1:0]   in_smp;
  int                    mismatches;

  function automatic logic [MV_W-1:0] trimmed_millivolts(input logic [CH_FIELD_W-1:0] ch);
    int unsigned total;
    int unsigned hi;
    int unsigned lo;
    int unsigned mean;
    total = 0;
    hi    = 0;
    lo    = SAMPLE_MAX;
    for (int i = 0; i < WINDOW_DEF; i++) begin
      if (ring[ch][i] > hi) hi = ring[ch][i];
      if (ring[ch][i] < lo) lo = ring[ch][i];
      total += ring[ch][i];
    end
    mean = (total - hi - lo) / (WINDOW_DEF - 2);
    return MV_W'((mean * full_scale) / FULL_CODE);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned act_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch: %s expected %0d actual %0d", what, exp_v, act_v);
    end
  endtask

  initial begin
    mismatches  = 0;
    err_count_o = 0;
    pending_o   = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS_DEF; c++) begin
        wr_pos[c] = '0;
        for (int w = 0; w < WINDOW_DEF; w++) ring[c][w] = '0;
      end
      full_scale   = FULL_SCALE_RST;
      chans_in_use = CHANS_RST;
      expected_readings.delete();
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FULL_SCALE: full_scale   = cfg_data_i[MV_W-1:0];
          CFG_CHANNELS:   chans_in_use = cfg_data_i[CHANS_W-1:0];
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result with no read pending, millivolts", 0, m_axis_tdata);
        end else begin
          want = expected_readings.pop_front();
          if (m_axis_tdata[MV_W-1:0] !== want.millivolts)
            report_mismatch("millivolts", want.millivolts, m_axis_tdata[MV_W-1:0]);
          if (m_axis_tdata[M_TDATA_W-1:MV_W] !== '0)
            report_mismatch("tdata padding", 0, m_axis_tdata[M_TDATA_W-1:MV_W]);
          if (m_axis_tuser !== want.invalid)
            report_mismatch("channel_invalid", want.invalid, m_axis_tuser);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        in_op  = s_axis_tuser;
        in_ch  = s_axis_tdata[CH_FIELD_W-1:0];
        in_smp = s_axis_tdata[CH_FIELD_W +: SAMPLE_W];
        if (in_op == OP_STORE) begin
          ring[in_ch][wr_pos[in_ch]] = in_smp;
          wr_pos[in_ch] = wr_pos[in_ch] + 1'b1;
        end else if (in_ch >= chans_in_use) begin
          want.millivolts = '0;
          want.invalid    = 1'b1;
          expected_readings.push_back(want);
        end else begin
          want.millivolts = trimmed_millivolts(in_ch);
          want.invalid    = 1'b0;
          expected_readings.push_back(want);
        end
      end

      pending_o   = expected_readings.size();
      err_count_o = mismatches;
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
module tb_top;
  import tmacv_pkg::*;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;   // channel[3:0], sample[15:4]
  logic                  s_axis_tuser  = 1'b0; // operation
  logic                  m_axis_tready = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [M_TDATA_W-1:0]  m_axis_tdata;         // millivolts[12:0], zero[15:13]
  logic                  m_axis_tuser;         // channel_invalid

  int err_count;
  int pending;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_req   = 0;
  int hold_len   = 400;
  int cur_chans  = CHANS_RST;

  trimmed_mean_adc_channel_voltage_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  voltage_read_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #7_200_000;
    $display("** trimmed_mean_adc_channel_voltage_top: FAILED **");
    $finish;
  end

  // result side: random stalls, plus a counted hold-off on request
  initial begin : rx_drive
    int seen;
    int cnt;
    seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != seen) begin
        seen = hold_req;
        m_axis_tready <= 1'b0;
        for (cnt = 0; cnt < hold_len; cnt++) @(posedge clk_i);
      end else if (rx_idle_en && $urandom_range(99) < 8) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic op, input logic [CH_FIELD_W-1:0] ch,
                           input logic [SAMPLE_W-1:0] smp);
    if (tx_idle_en && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {smp, ch};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold input until every read has returned, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random(input int n);
    int                    k;
    int                    lim;
    logic [CH_FIELD_W-1:0] focus;
    logic [CH_FIELD_W-1:0] ch;
    logic [SAMPLE_W-1:0]   base;
    logic [SAMPLE_W-1:0]   smp;
    logic                  op;
    lim   = (cur_chans > CHANNELS_DEF) ? CHANNELS_DEF : cur_chans;
    focus = CH_FIELD_W'($urandom_range(15));
    base  = SAMPLE_W'($urandom_range(4095));
    for (k = 0; k < n; k++) begin
      if (k == 0 || $urandom_range(19) == 0) begin
        focus = (lim > 0 && $urandom_range(3) != 0) ? CH_FIELD_W'($urandom_range(lim - 1))
                                                    : CH_FIELD_W'($urandom_range(15));
        base  = SAMPLE_W'($urandom_range(4095));
      end
      ch = ($urandom_range(9) < 7) ? focus : CH_FIELD_W'($urandom_range(15));
      op = ($urandom_range(9) >= 7) ? OP_READ : OP_STORE;
      case ($urandom_range(3))
        0: smp = SAMPLE_W'($urandom_range(4095));
        1: smp = $urandom_range(1) ? SAMPLE_MAX : '0;
        2: smp = base ^ SAMPLE_W'($urandom_range(7));
        default: smp = base;
      endcase
      send_item(op, ch, smp);
    end
  endtask

  task automatic run_phase(input int fs, input int chans, input int n);
    write_reg(CFG_FULL_SCALE, CFG_DATA_W'(fs));
    write_reg(CFG_CHANNELS, CFG_DATA_W'(chans));
    cur_chans = chans;
    send_random(n);
    drain();
  endtask

  initial begin : stimulus
    int i;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(OP_READ, 4'd0, '0);
    send_item(OP_READ, 4'd12, SAMPLE_MAX);
    send_item(OP_READ, 4'd13, '0);
    send_item(OP_READ, 4'd15, '0);
    for (i = 0; i < WINDOW_DEF; i++) send_item(OP_STORE, 4'd1, SAMPLE_MAX);
    send_item(OP_READ, 4'd1, '0);
    send_item(OP_STORE, 4'd1, '0);
    send_item(OP_READ, 4'd1, '0);
    send_item(OP_STORE, 4'd15, SAMPLE_MAX);
    send_item(OP_READ, 4'd15, '0);
    drain();

    run_phase(3000, 13, 250);
    run_phase(5000, 16, 250);
    run_phase(1, 1, 150);
    run_phase(0, 16, 150);

    write_reg(CFG_FULL_SCALE, 13'd8191);
    write_reg(CFG_CHANNELS, 13'd16);
    cur_chans  = 16;
    tx_idle_en = 1'b0;
    hold_len   = 400;
    hold_req++;
    send_random(120);
    drain();
    send_random(130);
    drain();
    tx_idle_en = 1'b1;

    run_phase(4095, 0, 100);
    run_phase(8191, 31, 200);

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_phase(2500, 8, 200);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    for (i = 0; i < 3; i++) run_phase($urandom_range(8191), $urandom_range(31), 100);

    @(negedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("** trimmed_mean_adc_channel_voltage_top: PASSED **");
    end else begin
      $display("** trimmed_mean_adc_channel_voltage_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
